// ===== rtl/core/lkt_pkg.sv =====
`default_nettype none

package lkt_pkg;

   // Capacity and stored key width
   localparam int LRU_DEPTH = 64;
   localparam int KEY_BITS  = 16;

   // Widths of the key fields on the ports
   localparam int PORT_KEY_W = 16;

   // Slot index / rank width and occupancy count width (count can hold LRU_DEPTH)
   localparam int IDX_W = $clog2(LRU_DEPTH);
   localparam int CNT_W = $clog2(LRU_DEPTH + 1);

   localparam logic [IDX_W-1:0] RANK_MAX  = IDX_W'(LRU_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(LRU_DEPTH);
   localparam logic [CNT_W-1:0] LIMIT_ALL = CNT_W'(LRU_DEPTH);
   localparam logic [CNT_W-1:0] LIMIT_OLD = CNT_W'(LRU_DEPTH - 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_AGE,
      ST_FINISH
   } lkt_state_type;

   // Access bundle from the sequencer to the key and rank memories
   typedef struct packed {
      logic                rd_en;
      logic [IDX_W-1:0]    rd_addr;
      logic [IDX_W-1:0]    wr_addr;
      logic                key_we;
      logic [KEY_BITS-1:0] key_wdata;
      logic                rank_we;
      logic [IDX_W-1:0]    rank_wdata;
   } lkt_mem_req_type;

endpackage

`default_nettype wire

// ===== rtl/core/lkt_ram.sv =====
`default_nettype none

module lkt_ram #(
   parameter int DATA_W = 16,
   parameter int DEPTH  = 64,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [DATA_W-1:0] wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lkt_ctrl.sv =====
`default_nettype none

module lkt_ctrl
   import lkt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PORT_KEY_W-1:0] req_key_index,
   input  wire logic                  req_handle_ok,
   output logic                       rsp_strobe,
   output logic                       rsp_accepted,
   output logic                       rsp_was_hit,
   output logic                       rsp_did_evict,
   output logic      [PORT_KEY_W-1:0] rsp_evicted_key,
   output lkt_mem_req_type            mem_req,
   input  wire logic [KEY_BITS-1:0]   key_rdata,
   input  wire logic [IDX_W-1:0]      rank_rdata
);

   lkt_state_type state_ff, state_in;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    addr_ff, addr_in;
   logic                pend_ff, pend_in;
   logic [IDX_W-1:0]    pidx_ff, pidx_in;
   logic [KEY_BITS-1:0] key_ff, key_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_slot_ff, hit_slot_in;
   logic [IDX_W-1:0]    hit_rank_ff, hit_rank_in;
   logic [IDX_W-1:0]    lru_slot_ff, lru_slot_in;
   logic [KEY_BITS-1:0] lru_key_ff, lru_key_in;
   logic                evict_ff, evict_in;
   logic [CNT_W-1:0]    limit_ff, limit_in;
   logic [IDX_W-1:0]    target_ff, target_in;

   logic                  strobe_ff, strobe_in;
   logic                  acc_ff, acc_in;
   logic                  was_hit_ff, was_hit_in;
   logic                  did_evict_ff, did_evict_in;
   logic [PORT_KEY_W-1:0] ev_key_ff, ev_key_in;

   logic issue;
   logic full;
   logic pass_done;

   // Walk the occupied slots, one read beat per cycle
   assign issue     = ((state_ff == ST_SCAN) || (state_ff == ST_AGE)) && (addr_ff < count_ff);
   assign pass_done = !issue && !pend_ff;
   assign full      = (count_ff == CNT_FULL);

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start && req_handle_ok) begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (pass_done) begin
               state_in = ST_AGE;
            end
         end
         ST_AGE: begin
            if (pass_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Datapath and memory accesses
   always_comb begin
      count_in     = count_ff;
      addr_in      = addr_ff;
      key_in       = key_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      hit_rank_in  = hit_rank_ff;
      lru_slot_in  = lru_slot_ff;
      lru_key_in   = lru_key_ff;
      evict_in     = evict_ff;
      limit_in     = limit_ff;
      target_in    = target_ff;
      strobe_in    = 1'b0;
      acc_in       = acc_ff;
      was_hit_in   = was_hit_ff;
      did_evict_in = did_evict_ff;
      ev_key_in    = ev_key_ff;

      mem_req            = '0;
      mem_req.rd_en      = issue;
      mem_req.rd_addr    = addr_ff[IDX_W-1:0];
      mem_req.wr_addr    = pidx_ff;
      mem_req.key_wdata  = key_ff;

      pend_in = issue;
      pidx_in = addr_ff[IDX_W-1:0];
      if (issue) begin
         addr_in = addr_ff + CNT_W'(1);
      end

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               key_in  = KEY_BITS'(req_key_index);
               addr_in = '0;
               hit_in  = 1'b0;
               // Ignored item: answer at once with an all-zero beat
               if (!req_handle_ok) begin
                  strobe_in    = 1'b1;
                  acc_in       = 1'b0;
                  was_hit_in   = 1'b0;
                  did_evict_in = 1'b0;
                  ev_key_in    = '0;
               end
            end
         end
         ST_SCAN: begin
            // Look for the key and for the oldest slot
            if (pend_ff) begin
               if ((key_rdata == key_ff) && !hit_ff) begin
                  hit_in      = 1'b1;
                  hit_slot_in = pidx_ff;
                  hit_rank_in = rank_rdata;
               end
               if (rank_rdata == RANK_MAX) begin
                  lru_slot_in = pidx_ff;
                  lru_key_in  = key_rdata;
               end
            end
            // Choose the ageing limit and the slot that becomes most recent
            if (pass_done) begin
               addr_in  = '0;
               evict_in = !hit_ff && full;
               if (hit_ff) begin
                  limit_in  = CNT_W'(hit_rank_ff);
                  target_in = hit_slot_ff;
               end else if (full) begin
                  limit_in  = LIMIT_OLD;
                  target_in = lru_slot_ff;
               end else begin
                  limit_in  = LIMIT_ALL;
                  target_in = count_ff[IDX_W-1:0];
               end
            end
         end
         ST_AGE: begin
            // Age every slot younger than the limit, clear the target
            if (pend_ff) begin
               mem_req.rank_we = 1'b1;
               if (pidx_ff == target_ff) begin
                  mem_req.rank_wdata = '0;
               end else if (CNT_W'(rank_rdata) < limit_ff) begin
                  mem_req.rank_wdata = rank_rdata + IDX_W'(1);
               end else begin
                  mem_req.rank_wdata = rank_rdata;
               end
            end
         end
         ST_FINISH: begin
            // Place the key on a miss and mark the target most recent
            mem_req.wr_addr    = target_ff;
            mem_req.key_we     = !hit_ff;
            mem_req.rank_we    = 1'b1;
            mem_req.rank_wdata = '0;
            if (!hit_ff && !full) begin
               count_in = count_ff + CNT_W'(1);
            end
            strobe_in    = 1'b1;
            acc_in       = 1'b1;
            was_hit_in   = hit_ff;
            did_evict_in = evict_ff;
            ev_key_in    = evict_ff ? PORT_KEY_W'(lru_key_ff) : '0;
         end
         default: begin
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         count_ff  <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      pidx_ff      <= pidx_in;
      key_ff       <= key_in;
      hit_ff       <= hit_in;
      hit_slot_ff  <= hit_slot_in;
      hit_rank_ff  <= hit_rank_in;
      lru_slot_ff  <= lru_slot_in;
      lru_key_ff   <= lru_key_in;
      evict_ff     <= evict_in;
      limit_ff     <= limit_in;
      target_ff    <= target_in;
      acc_ff       <= acc_in;
      was_hit_ff   <= was_hit_in;
      did_evict_ff <= did_evict_in;
      ev_key_ff    <= ev_key_in;
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_accepted    = acc_ff;
   assign rsp_was_hit     = was_hit_ff;
   assign rsp_did_evict   = did_evict_ff;
   assign rsp_evicted_key = ev_key_ff;

endmodule

`default_nettype wire

// ===== rtl/core/lru_key_tracker.sv =====
`default_nettype none

// Recency list of up to 64 keys. Pulse start with a key while busy is low;
// exactly one result beat follows on rsp_strobe for one cycle, and it must be
// taken then, as there is no way to hold it off. An item with handle_ok low
// changes nothing and answers on the next cycle. A valid item keeps busy high
// through one pass over the occupied slots of the key and rank memories to
// find the key and the oldest slot, a second read-modify-write pass over
// the rank memory to age the entries, and a final step that writes the
// key. busy falls in the cycle the result beat is shown, so the next item
// may start there.
module lru_key_tracker
   import lkt_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [PORT_KEY_W-1:0] req_key_index,
   input  wire logic                  req_handle_ok,
   output logic                       rsp_strobe,
   output logic                       rsp_accepted,
   output logic                       rsp_was_hit,
   output logic                       rsp_did_evict,
   output logic      [PORT_KEY_W-1:0] rsp_evicted_key
);

   lkt_mem_req_type     mem_req;
   logic [KEY_BITS-1:0] key_rdata;
   logic [IDX_W-1:0]    rank_rdata;

   // Sequencer
   lkt_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_index   (req_key_index),
      .req_handle_ok   (req_handle_ok),
      .rsp_strobe      (rsp_strobe),
      .rsp_accepted    (rsp_accepted),
      .rsp_was_hit     (rsp_was_hit),
      .rsp_did_evict   (rsp_did_evict),
      .rsp_evicted_key (rsp_evicted_key),
      .mem_req         (mem_req),
      .key_rdata       (key_rdata),
      .rank_rdata      (rank_rdata)
   );

   // Key held in each slot
   lkt_ram #(
      .DATA_W (KEY_BITS),
      .DEPTH  (LRU_DEPTH)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (mem_req.key_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.key_wdata),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (key_rdata)
   );

   // Recency rank of each slot
   lkt_ram #(
      .DATA_W (IDX_W),
      .DEPTH  (LRU_DEPTH)
   ) u_rank_ram (
      .clock   (clock),
      .wr_en   (mem_req.rank_we),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.rank_wdata),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (rank_rdata)
   );

endmodule

`default_nettype wire

// ===== rtl/core/lkt_checker.sv =====
`default_nettype none

module lkt_checker
   import lkt_pkg::*;
(
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire logic                  req_handle_ok,
   input wire logic                  rsp_strobe,
   input wire logic                  rsp_accepted,
   input wire logic                  rsp_was_hit,
   input wire logic                  rsp_did_evict,
   input wire logic [PORT_KEY_W-1:0] rsp_evicted_key
);

   // A result beat is only shown once the block is free again
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while busy");

   // Ignored item answers on the next cycle with an all-zero beat
   a_ignore: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_handle_ok) |=> (rsp_strobe && !rsp_accepted))
      else $error("ignored item not answered at once");

   // A valid item keeps the block busy
   a_valid_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_handle_ok) |=> (busy && !rsp_strobe))
      else $error("valid item not taken up");

   // Hit, eviction and evicted key stay consistent
   a_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (!(rsp_was_hit && rsp_did_evict)
                      && (rsp_accepted || (!rsp_was_hit && !rsp_did_evict))
                      && (rsp_did_evict || (rsp_evicted_key == '0))))
      else $error("inconsistent result fields");

endmodule

bind lru_key_tracker lkt_checker u_lkt_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_handle_ok   (req_handle_ok),
   .rsp_strobe      (rsp_strobe),
   .rsp_accepted    (rsp_accepted),
   .rsp_was_hit     (rsp_was_hit),
   .rsp_did_evict   (rsp_did_evict),
   .rsp_evicted_key (rsp_evicted_key)
);

`default_nettype wire

// ===== sim/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import lkt_pkg::*;

   // One access as queued for the driver; hold_drain makes the driver wait
   // until every outstanding result beat has arrived before offering it.
   typedef struct {
      logic [PORT_KEY_W-1:0] key_index;
      logic                  handle_ok;
      bit                    hold_drain;
   } access_beat_t;

   typedef struct {
      logic                  accepted;
      logic                  was_hit;
      logic                  did_evict;
      logic [PORT_KEY_W-1:0] evicted_key;
   } tracker_result_t;

   logic                  clock           = 1'b0;
   logic                  reset           = 1'b1;
   logic                  start           = 1'b0;
   logic [PORT_KEY_W-1:0] req_key_index   = '0;
   logic                  req_handle_ok   = 1'b0;
   logic                  busy;
   logic                  rsp_strobe;
   logic                  rsp_accepted;
   logic                  rsp_was_hit;
   logic                  rsp_did_evict;
   logic [PORT_KEY_W-1:0] rsp_evicted_key;

   access_beat_t          pending_accesses[$];
   tracker_result_t       expected_results[$];
   // Held keys, most recent first
   logic [KEY_BITS-1:0]   recency_order[$];

   int                    error_count = 0;
   int                    burst_left  = 1;
   int                    gap_left    = 0;

   lru_key_tracker uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_key_index   (req_key_index),
      .req_handle_ok   (req_handle_ok),
      .rsp_strobe      (rsp_strobe),
      .rsp_accepted    (rsp_accepted),
      .rsp_was_hit     (rsp_was_hit),
      .rsp_did_evict   (rsp_did_evict),
      .rsp_evicted_key (rsp_evicted_key)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Apply one access to the recency order and return the result it yields
   function automatic tracker_result_t touch_key(logic [PORT_KEY_W-1:0] key_in,
                                                 logic ok);
      tracker_result_t     res;
      logic [KEY_BITS-1:0] key;
      int                  pos;
      res = '{1'b0, 1'b0, 1'b0, '0};
      key = KEY_BITS'(key_in);
      pos = -1;
      if (!ok)
         return res;
      res.accepted = 1'b1;
      foreach (recency_order[j]) begin
         if (pos < 0 && recency_order[j] == key)
            pos = j;
      end
      if (pos >= 0) begin
         res.was_hit = 1'b1;
         recency_order.delete(pos);
      end else if (recency_order.size() == LRU_DEPTH) begin
         res.did_evict   = 1'b1;
         res.evicted_key = PORT_KEY_W'(recency_order[$]);
         recency_order.delete(recency_order.size() - 1);
      end
      recency_order.insert(0, key);
      return res;
   endfunction

   function automatic void queue_access(logic [PORT_KEY_W-1:0] key, logic ok,
                                        bit drain = 1'b0);
      access_beat_t beat;
      beat.key_index  = key;
      beat.handle_ok  = ok;
      beat.hold_drain = drain;
      pending_accesses.insert(pending_accesses.size(), beat);
   endfunction

   // Driver: predict on each accepted beat, then offer the next one in bursts
   always @(posedge clock) begin
      access_beat_t    next_beat;
      tracker_result_t predicted;
      if (!reset) begin
         if (start && !busy) begin
            predicted = touch_key(req_key_index, req_handle_ok);
            expected_results.insert(expected_results.size(), predicted);
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = $urandom_range(1, 20);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
            end
         end
         // hold the beat while the block is busy
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               start <= 1'b0;
               gap_left--;
            end else if (pending_accesses.size() != 0 &&
                         !(pending_accesses[0].hold_drain &&
                           expected_results.size() != 0)) begin
               next_beat = pending_accesses[0];
               pending_accesses.delete(0);
               start         <= 1'b1;
               req_key_index <= next_beat.key_index;
               req_handle_ok <= next_beat.handle_ok;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare every result beat with the oldest prediction
   always @(posedge clock) begin
      tracker_result_t want;
      if (!reset && rsp_strobe) begin
         if (expected_results.size() == 0) begin
            error_count++;
            if (error_count <= 10)
               $display("%0t: unexpected beat: acc=%0b hit=%0b evict=%0b key=%h",
                        $realtime, rsp_accepted, rsp_was_hit, rsp_did_evict,
                        rsp_evicted_key);
         end else begin
            want = expected_results[0];
            expected_results.delete(0);
            if (rsp_accepted !== want.accepted || rsp_was_hit !== want.was_hit ||
                rsp_did_evict !== want.did_evict || rsp_evicted_key !== want.evicted_key) begin
               error_count++;
               if (error_count <= 10)
                  $display("%0t: mismatch: expected acc=%0b hit=%0b evict=%0b key=%h,",
                           $realtime, want.accepted, want.was_hit, want.did_evict,
                           want.evicted_key,
                           " got acc=%0b hit=%0b evict=%0b key=%h",
                           rsp_accepted, rsp_was_hit, rsp_did_evict, rsp_evicted_key);
            end
         end
      end
   end

   // Stimulus and end of run
   initial begin
      logic [PORT_KEY_W-1:0] key_pool[80];
      int                    valid_count;
      int                    pool_size;
      logic [PORT_KEY_W-1:0] key;

      // directed: empty store, extremes, hits at each end of the order, ignored beats
      queue_access(16'hFFFF, 1'b0);
      queue_access(16'h0000, 1'b0);
      queue_access(16'h0000, 1'b1);
      queue_access(16'hFFFF, 1'b1);
      queue_access(16'h5555, 1'b1);
      queue_access(16'hAAAA, 1'b1);
      queue_access(16'hAAAA, 1'b1);
      queue_access(16'h0000, 1'b1);
      queue_access(16'h5555, 1'b1);
      queue_access(16'hFFFF, 1'b0, 1'b1);
      queue_access(16'hFFFF, 1'b1);
      queue_access(16'h0001, 1'b1);
      queue_access(16'h8000, 1'b1);
      queue_access(16'h1234, 1'b0);
      queue_access(16'h0001, 1'b1);

      foreach (key_pool[j])
         key_pool[j] = PORT_KEY_W'($urandom_range(0, 16'hFFFF));
      key_pool[0] = 16'h0000;
      key_pool[1] = 16'hFFFF;

      // random: phases of pool sizes give hit-heavy, thrashing and miss-heavy traffic
      valid_count = 0;
      while (valid_count < 520) begin
         case ((valid_count / 100) % 4)
            0: pool_size = 16;
            1: pool_size = 66;
            2: pool_size = 80;
            default: pool_size = 0;
         endcase
         if (pool_size == 0 || $urandom_range(0, 15) == 0)
            key = PORT_KEY_W'($urandom_range(0, 16'hFFFF));
         else
            key = key_pool[$urandom_range(0, pool_size - 1)];
         if ($urandom_range(0, 7) == 0) begin
            queue_access(key, 1'b0);
         end else begin
            queue_access(key, 1'b1, (valid_count % 97) == 50);
            valid_count++;
         end
      end

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // drain, then allow for a late spurious beat
      do
         @(negedge clock);
      while (pending_accesses.size() != 0 || start || expected_results.size() != 0);
      repeat (200) @(negedge clock);

      if (error_count == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #10_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== lru_key_tracker.f =====
rtl/core/lkt_pkg.sv
rtl/core/lkt_ram.sv
rtl/core/lkt_ctrl.sv
rtl/core/lru_key_tracker.sv
rtl/core/lkt_checker.sv
sim/tb.sv
